[rtl/byte_ring_fifo_assert.svh]
// assertion macros for the byte ring fifo
// both sample on clk and are switched off while rst_n is low
`ifndef BYTE_RING_FIFO_ASSERT_SVH
`define BYTE_RING_FIFO_ASSERT_SVH

// same-cycle implication
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/brf_pkg.sv]
package brf_pkg;

  localparam int CNT_W       = 13;
  localparam int OP_W        = 2;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;
  localparam int CAP_MAX     = (1 << CNT_W) - 1;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;

  // outcome of one request, less the byte read back from the store
  typedef struct packed {
    logic read_valid;
    logic write_accepted;
    cnt_t fill;
    cnt_t free;
  } res_t;

endpackage

[rtl/brf_ram.sv]
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/brf_ctrl.sv]
module brf_ctrl #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [brf_pkg::OP_W-1:0] op,
  input  brf_pkg::cnt_t           cap,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_addr,
  output brf_pkg::res_t           res
);

  import brf_pkg::*;

  localparam int XW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  cnt_t          stored_r, stored_nxt;
  logic          rd_ok, wr_ok;

  // step a position, wrapping at the capacity in use
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos, input cnt_t c);
    logic [XW-1:0] inc;
    inc = XW'(pos) + XW'(1);
    return (inc >= XW'(c)) ? '0 : inc[AW-1:0];
  endfunction

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    stored_nxt = stored_r;
    rd_ok      = 1'b0;
    wr_ok      = 1'b0;
    mem_addr   = head_r;
    unique case (op)
      OP_WRITE: begin
        mem_addr = tail_r;
        if (stored_r < cap) begin
          wr_ok      = 1'b1;
          tail_nxt   = advance(tail_r, cap);
          stored_nxt = stored_r + cnt_t'(1);
        end
      end
      OP_READ: begin
        if (stored_r != '0) begin
          rd_ok      = 1'b1;
          head_nxt   = advance(head_r, cap);
          stored_nxt = stored_r - cnt_t'(1);
          // emptied: both positions back to the start
          if (stored_r == cnt_t'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
      end
      OP_CLEAR: begin
        head_nxt   = '0;
        tail_nxt   = '0;
        stored_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign mem_we             = accept && wr_ok;
  assign res.read_valid     = rd_ok;
  assign res.write_accepted = wr_ok;
  assign res.fill           = stored_nxt;
  assign res.free           = (stored_nxt > cap) ? '0 : cap - stored_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      stored_r <= '0;
    end else if (accept) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      stored_r <= stored_nxt;
    end
  end

endmodule

[rtl/byte_ring_fifo.sv]
// channel  dir  handshake                  payload
// in       in   in_tvalid / in_tready      tdata data_byte, tuser op
// out      out  out_tvalid / out_tready    tdata read_byte fill free, tuser flags
// cfg      in   cfg_valid / cfg_ready      capacity_in_use
//
// write, clear, spare op codes and a read of an empty fifo load the result register directly
// a read that returns a byte passes through a read state: the store is one single-port ram with
// registered read
// reset is synchronous on rst_n; the store itself is not cleared, only positions, count, capacity and state
// results sit in an output register, so a new request is taken in the cycle the last
// result leaves; while a result waits and is not taken, in_tready stays low
module byte_ring_fifo #(
  parameter int DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [brf_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic [brf_pkg::IN_TUSER_W-1:0]    in_tuser,   // [1:0] op
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [brf_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] read_byte, [20:8] fill_count,
                                                        // [33:21] free_count, [39:34] zero
  output logic [brf_pkg::OUT_TUSER_W-1:0]   out_tuser,  // [0] read_valid, [1] write_accepted
  // capacity register
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [brf_pkg::CNT_W-1:0]         cfg_data
);

  import brf_pkg::*;

  `include "byte_ring_fifo_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int XW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam cnt_t CAP_RST = cnt_t'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic                   state_r, state_nxt;
  cnt_t                   cap_r, cap_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;
  res_t                   pend_r;

  logic                   in_fire;
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [BYTE_W-1:0]      mem_rdata;
  res_t                   res;

  // capacity is clamped to 1..DEPTH as it is written
  assign cfg_ready = 1'b1;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_valid) begin
      if (cfg_data == '0) begin
        cap_nxt = cnt_t'(1);
      end else if (XW'(cfg_data) > DEPTH_X) begin
        cap_nxt = DEPTH_X[CNT_W-1:0];
      end else begin
        cap_nxt = cfg_data;
      end
    end
  end

  // new request only when no read is in flight and the result slot is free or leaving
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  brf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_fire),
    .op       (in_tuser),
    .cap      (cap_r),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .res      (res)
  );

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_tdata[BYTE_W-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // a successful read goes to the read state to wait for the ram's registered data
          if (res.read_valid) begin
            state_nxt = ST_RD;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= res;
    end
    if (state_r == ST_RD) begin
      out_data_r <= {(OUT_TDATA_W - 2 * CNT_W - BYTE_W)'(0), pend_r.free, pend_r.fill, mem_rdata};
      out_user_r <= {pend_r.write_accepted, pend_r.read_valid};
    end else if (in_fire && !res.read_valid) begin
      out_data_r <= {(OUT_TDATA_W - 2 * CNT_W - BYTE_W)'(0), res.free, res.fill, BYTE_W'(0)};
      out_user_r <= {res.write_accepted, res.read_valid};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  `BRF_ASSERT_NEXT(a_rd_result, state_r == ST_RD, out_valid_r, "read result not presented")
  `BRF_ASSERT_NOW(a_flags_excl, out_valid_r, !(out_user_r[0] && out_user_r[1]),
    "read and write flags both set")
  `BRF_ASSERT_NOW(a_wr_fill, out_valid_r && out_user_r[1],
    out_data_r[BYTE_W +: CNT_W] != '0, "accepted write left fifo empty")

endmodule
